### rtl/blris_pkg.sv
// Shared types and constants for the bounded list core.
`timescale 1ns / 1ps
package blris_pkg;

    localparam int CAPACITY = 64;
    localparam int AW       = $clog2(CAPACITY);
    localparam int CW       = AW + 1;
    localparam int DW       = 32;

    typedef enum logic [2:0] {
        MODE_APPEND  = 3'd0,
        MODE_PREPEND = 3'd1,
        MODE_INSERT  = 3'd2,
        MODE_REMOVE  = 3'd3,
        MODE_SEARCH  = 3'd4
    } t_mode;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2,
        ST_MISS  = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SHIFT,
        S_DRAIN,
        S_PUT,
        S_SCAN,
        S_DONE
    } t_state;

    typedef struct packed {
        t_status         status;
        logic [AW-1:0]   found;
        logic [CW-1:0]   count;
    } t_result;

    typedef struct packed {
        logic            we;
        logic [AW-1:0]   addr;
        logic [DW-1:0]   data;
    } t_mem_wr;

endpackage

### rtl/blris_store.sv
// Element store: one write port, one registered read port.
`timescale 1ns / 1ps
module blris_store
    import blris_pkg::*;
(
    input  logic          i_clk,
    input  t_mem_wr       i_wr,
    input  logic [AW-1:0] i_rd_addr,
    output logic [DW-1:0] o_rd_data
);

    logic [DW-1:0] r_mem [CAPACITY];
    logic [DW-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

### rtl/blris_ctrl.sv
// Sequencer: decodes a request, steps the shared pointer unit through the store.
`timescale 1ns / 1ps
module blris_ctrl
    import blris_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_req_valid,
    output logic          o_req_ready,
    input  logic [2:0]    i_mode,
    input  logic [CW-1:0] i_position,
    input  logic [DW-1:0] i_value,
    output logic          o_res_valid,
    input  logic          i_res_ready,
    output t_result       o_res,
    output t_mem_wr       o_wr,
    output logic [AW-1:0] o_rd_addr,
    input  logic [DW-1:0] i_rd_data
);

    t_state        r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [AW-1:0] r_ptr, n_ptr;
    logic [AW-1:0] r_last, n_last;
    logic [AW-1:0] r_wa, n_wa;
    logic [AW-1:0] r_slot, n_slot;
    logic [AW-1:0] r_cidx, n_cidx;
    logic          r_pend, n_pend;
    logic          r_up, n_up;
    logic [DW-1:0] r_val, n_val;
    t_result       r_res, n_res;

    logic          full;
    logic [CW-1:0] ins_pos;
    logic [CW-1:0] cnt_m1;
    logic          at_last;
    logic [AW-1:0] ptr_next;
    logic [AW-1:0] ptr_wr;

    function automatic t_result mk_res(t_status s, logic [AW-1:0] f, logic [CW-1:0] c);
        t_result r;
        r.status = s;
        r.found  = f;
        r.count  = c;
        return r;
    endfunction

    assign full     = (r_count == CW'(CAPACITY));
    assign cnt_m1   = r_count - CW'(1);
    assign at_last  = (r_ptr == r_last);
    assign ptr_next = r_up ? r_ptr - AW'(1) : r_ptr + AW'(1);
    assign ptr_wr   = r_up ? r_ptr + AW'(1) : r_ptr - AW'(1);

    always_comb begin
        unique case (t_mode'(i_mode))
            MODE_APPEND:  ins_pos = r_count;
            MODE_PREPEND: ins_pos = '0;
            default:      ins_pos = i_position;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_count <= n_count;
            r_pend  <= n_pend;
        end
        r_ptr  <= n_ptr;
        r_last <= n_last;
        r_wa   <= n_wa;
        r_slot <= n_slot;
        r_cidx <= n_cidx;
        r_up   <= n_up;
        r_val  <= n_val;
        r_res  <= n_res;
    end

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_ptr     = r_ptr;
        n_last    = r_last;
        n_wa      = r_wa;
        n_slot    = r_slot;
        n_cidx    = r_cidx;
        n_pend    = r_pend;
        n_up      = r_up;
        n_val     = r_val;
        n_res     = r_res;
        o_wr      = '{we: 1'b0, addr: r_wa, data: i_rd_data};
        o_rd_addr = r_ptr;

        unique case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    n_val   = i_value;
                    n_pend  = 1'b0;
                    n_state = S_DONE;
                    n_res   = mk_res(ST_RANGE, '0, r_count);
                    unique case (i_mode)
                        MODE_APPEND, MODE_PREPEND, MODE_INSERT: begin
                            if (ins_pos > r_count) begin
                                n_res = mk_res(ST_RANGE, '0, r_count);
                            end else if (full) begin
                                n_res = mk_res(ST_FULL, '0, r_count);
                            end else if (ins_pos == r_count) begin
                                o_wr    = '{we: 1'b1, addr: ins_pos[AW-1:0], data: i_value};
                                n_count = r_count + CW'(1);
                                n_res   = mk_res(ST_OK, '0, r_count + CW'(1));
                            end else begin
                                n_slot  = ins_pos[AW-1:0];
                                n_ptr   = cnt_m1[AW-1:0];
                                n_last  = ins_pos[AW-1:0];
                                n_up    = 1'b1;
                                n_state = S_SHIFT;
                            end
                        end
                        MODE_REMOVE: begin
                            if (i_position >= r_count) begin
                                n_res = mk_res(ST_RANGE, '0, r_count);
                            end else if (i_position == cnt_m1) begin
                                n_count = cnt_m1;
                                n_res   = mk_res(ST_OK, '0, cnt_m1);
                            end else begin
                                n_ptr   = i_position[AW-1:0] + AW'(1);
                                n_last  = cnt_m1[AW-1:0];
                                n_up    = 1'b0;
                                n_state = S_SHIFT;
                            end
                        end
                        MODE_SEARCH: begin
                            if (r_count == '0) begin
                                n_res = mk_res(ST_MISS, '0, r_count);
                            end else begin
                                n_ptr   = '0;
                                n_state = S_SCAN;
                            end
                        end
                        default: begin
                            n_res = mk_res(ST_RANGE, '0, r_count);
                        end
                    endcase
                end
            end
            S_SHIFT: begin
                o_wr.we = r_pend;
                n_pend  = 1'b1;
                n_wa    = ptr_wr;
                if (at_last) begin
                    n_state = S_DRAIN;
                end else begin
                    n_ptr = ptr_next;
                end
            end
            S_DRAIN: begin
                o_wr.we = 1'b1;
                n_pend  = 1'b0;
                if (r_up) begin
                    n_state = S_PUT;
                end else begin
                    n_count = cnt_m1;
                    n_res   = mk_res(ST_OK, '0, cnt_m1);
                    n_state = S_DONE;
                end
            end
            S_PUT: begin
                o_wr    = '{we: 1'b1, addr: r_slot, data: r_val};
                n_count = r_count + CW'(1);
                n_res   = mk_res(ST_OK, '0, r_count + CW'(1));
                n_state = S_DONE;
            end
            S_SCAN: begin
                n_ptr  = r_ptr + AW'(1);
                n_cidx = r_ptr;
                n_pend = 1'b1;
                if (r_pend && (i_rd_data == r_val)) begin
                    n_pend  = 1'b0;
                    n_res   = mk_res(ST_OK, r_cidx, r_count);
                    n_state = S_DONE;
                end else if (r_pend && ({1'b0, r_cidx} == cnt_m1)) begin
                    n_pend  = 1'b0;
                    n_res   = mk_res(ST_MISS, '0, r_count);
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_req_ready = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_DONE);
    assign o_res       = r_res;

endmodule

### rtl/bounded_list_insert_remove_search_core.sv
// Top level of the bounded list core: sequencer, element store and result register.
//
//   channel   direction   handshake                    payload
//   request   in          i_req_valid / o_req_ready    i_mode, i_position, i_value
//   result    out         o_res_valid / i_res_ready    o_status, o_found_index, o_count_after
//
// Append, a remove of the last element and every refused request move no elements.
// Insert at p shifts elements p to count - 1 up, remove at p shifts later ones down,
// search scans from index 0: the single store read port moves one element a cycle.
// Reset clears the count and control only; store contents are not cleared.
// A result waits in the output register while the next request is taken.
`timescale 1ns / 1ps
module bounded_list_insert_remove_search_core
    import blris_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_req_valid,
    output logic                 o_req_ready,
    input  logic [2:0]           i_mode,
    input  logic [CW-1:0]        i_position,
    input  logic signed [DW-1:0] i_value,
    output logic                 o_res_valid,
    input  logic                 i_res_ready,
    output logic [1:0]           o_status,
    output logic [AW-1:0]        o_found_index,
    output logic [CW-1:0]        o_count_after
);

    t_mem_wr       wr;
    logic [AW-1:0] rd_addr;
    logic [DW-1:0] rd_data;
    logic          res_valid;
    logic          res_take;
    t_result       res;
    logic          r_out_valid;
    t_result       r_out;

    assign res_take = !r_out_valid || i_res_ready;

    blris_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_ready (o_req_ready),
        .i_mode      (i_mode),
        .i_position  (i_position),
        .i_value     (i_value),
        .o_res_valid (res_valid),
        .i_res_ready (res_take),
        .o_res       (res),
        .o_wr        (wr),
        .o_rd_addr   (rd_addr),
        .i_rd_data   (rd_data)
    );

    blris_store u_store (
        .i_clk     (i_clk),
        .i_wr      (wr),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid && res_take) begin
            r_out_valid <= 1'b1;
        end else if (i_res_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid && res_take) begin
            r_out <= res;
        end
    end

    assign o_res_valid   = r_out_valid;
    assign o_status      = r_out.status;
    assign o_found_index = r_out.found;
    assign o_count_after = r_out.count;

    a_busy_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && o_req_ready) |=> !o_req_ready)
        else $error("request taken while previous one still in progress");

    a_found_only_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && (o_found_index != '0)) |-> (o_status == ST_OK))
        else $error("nonzero found index on a failed result");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> (o_count_after <= CW'(CAPACITY)))
        else $error("count beyond capacity");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && (o_status == ST_FULL)) |-> (o_count_after == CW'(CAPACITY)))
        else $error("full status with room left");

endmodule
